>>> hw/rtl/bgpbps_pkg.sv
`default_nettype none

package bgpbps_pkg;

    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STAT_SKIP         = 2'd0;
    localparam logic [1:0] STAT_UNRESOLVABLE = 2'd1;
    localparam logic [1:0] STAT_RESOLVABLE   = 2'd2;
    localparam logic [1:0] STAT_WINNER       = 2'd3;

    typedef enum logic [1:0] {
        ACT_IGNORE,
        ACT_WINNER,
        ACT_COMPETE
    } action_t;

    typedef struct packed {
        logic [1:0]  candidate_status;
        logic [31:0] local_preference;
        logic [7:0]  as_path_length;
        logic [1:0]  origin_code;
        logic [31:0] multi_exit_disc;
        logic [31:0] neighbour_as;
        logic        from_internal_peer;
        logic [31:0] igp_metric;
        logic [31:0] peer_router_id;
        logic [31:0] peer_address;
        logic        last_candidate;
    } cand_t;

    typedef struct packed {
        logic             winner_found;
        logic [IDX_W-1:0] winner_index;
        logic             winner_was_incumbent;
    } result_t;

    typedef struct packed {
        action_t          action;
        logic [IDX_W-1:0] index;
        logic             last;
        cand_t            cand;
    } work_t;

endpackage

`default_nettype wire

>>> hw/rtl/bgpbps_front.sv
`default_nettype none

module bgpbps_front #(
    parameter int MAX_CANDIDATES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bgpbps_pkg::cand_t  s_data,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output bgpbps_pkg::work_t       push_data
);
    import bgpbps_pkg::*;

    localparam int PW = $clog2(MAX_CANDIDATES + 1);

    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       pos_next;
    logic [PW+IDX_W-1:0] pos_ext;
    logic                in_range;
    logic                accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;
    assign in_range   = pos_reg < PW'(MAX_CANDIDATES);
    assign pos_ext    = {{IDX_W{1'b0}}, pos_reg};

    always_comb begin
        push_data       = '0;
        push_data.cand  = s_data;
        push_data.index = pos_ext[IDX_W-1:0];
        push_data.last  = s_data.last_candidate;
        if (!in_range) begin
            push_data.action = ACT_IGNORE;
        end else begin
            unique case (s_data.candidate_status) inside
                STAT_SKIP, STAT_UNRESOLVABLE: push_data.action = ACT_IGNORE;
                STAT_RESOLVABLE:              push_data.action = ACT_COMPETE;
                STAT_WINNER:                  push_data.action = ACT_WINNER;
                default:                      push_data.action = ACT_IGNORE;
            endcase
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_data.last_candidate) begin
                pos_next = '0;
            end else if (in_range) begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bgpbps_queue.sv
`default_nettype none

module bgpbps_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire bgpbps_pkg::work_t  push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output bgpbps_pkg::work_t       pop_data
);
    import bgpbps_pkg::*;

    work_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bgpbps_back.sv
`default_nettype none

module bgpbps_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire bgpbps_pkg::work_t  pop_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bgpbps_pkg::result_t     m_data
);
    import bgpbps_pkg::*;

    logic             have_best_reg;
    logic             have_best_next;
    logic             locked_reg;
    logic             locked_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    cand_t            best_reg;
    cand_t            best_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    result_t          m_data_reg;
    result_t          m_data_next;
    logic             pop;
    logic             beats;
    logic             take;
    logic             have_upd;
    logic             locked_upd;
    logic [IDX_W-1:0] idx_upd;
    cand_t            c;

    assign c         = pop_data.cand;
    assign pop_ready = !pop_data.last || !m_valid_reg || m_ready;
    assign pop       = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        beats = 1'b0;
        if (c.local_preference != best_reg.local_preference) begin
            beats = c.local_preference > best_reg.local_preference;
        end else if (c.as_path_length != best_reg.as_path_length) begin
            beats = c.as_path_length < best_reg.as_path_length;
        end else if (c.origin_code != best_reg.origin_code) begin
            beats = c.origin_code < best_reg.origin_code;
        end else if (c.neighbour_as == best_reg.neighbour_as
                     && c.multi_exit_disc != best_reg.multi_exit_disc) begin
            beats = c.multi_exit_disc < best_reg.multi_exit_disc;
        end else if (c.from_internal_peer != best_reg.from_internal_peer) begin
            beats = !c.from_internal_peer;
        end else if (c.igp_metric != best_reg.igp_metric) begin
            beats = c.igp_metric < best_reg.igp_metric;
        end else if (c.peer_router_id != best_reg.peer_router_id) begin
            beats = c.peer_router_id < best_reg.peer_router_id;
        end else if (c.peer_address != best_reg.peer_address) begin
            beats = c.peer_address < best_reg.peer_address;
        end
    end

    always_comb begin
        unique case (pop_data.action)
            ACT_WINNER:  take = !locked_reg;
            ACT_COMPETE: take = !locked_reg && (!have_best_reg || beats);
            ACT_IGNORE:  take = 1'b0;
            default:     take = 1'b0;
        endcase
    end

    always_comb begin
        have_upd   = have_best_reg;
        locked_upd = locked_reg;
        idx_upd    = best_idx_reg;
        best_next  = best_reg;
        if (pop && take) begin
            have_upd  = 1'b1;
            idx_upd   = pop_data.index;
            best_next = c;
            if (pop_data.action == ACT_WINNER) begin
                locked_upd = 1'b1;
            end
        end

        m_data_next                      = m_data_reg;
        m_valid_next                     = m_valid_reg && !m_ready;
        have_best_next                   = have_upd;
        locked_next                      = locked_upd;
        best_idx_next                    = idx_upd;
        if (pop && pop_data.last) begin
            m_valid_next                     = 1'b1;
            m_data_next.winner_found         = have_upd;
            m_data_next.winner_index         = have_upd ? idx_upd : '0;
            m_data_next.winner_was_incumbent = have_upd && locked_upd;
            have_best_next                   = 1'b0;
            locked_next                      = 1'b0;
            best_idx_next                    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            locked_reg    <= 1'b0;
            best_idx_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            have_best_reg <= have_best_next;
            locked_reg    <= locked_next;
            best_idx_reg  <= best_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg   <= best_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/bgp_best_path_select.sv
// A last candidate is registered in the queue, then its result in m_data_reg.
// Throughput: one candidate and one compare per cycle unless a result is stalled.
// A 2-entry queue separates the classify stage from the compare stage.
// Reset: synchronous, active low; clears the queue, run counter and held best.
`default_nettype none

module bgp_best_path_select #(
    parameter int MAX_CANDIDATES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bgpbps_pkg::cand_t    s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bgpbps_pkg::result_t       m_data
);
    import bgpbps_pkg::*;

    logic  push_valid;
    logic  push_ready;
    work_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    work_t pop_data;

    bgpbps_front #(
        .MAX_CANDIDATES(MAX_CANDIDATES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bgpbps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bgpbps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bgpbps_checker.sv
`default_nettype none

module bgpbps_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire bgpbps_pkg::result_t  m_data
);
    import bgpbps_pkg::*;

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.winner_found
            |-> m_data.winner_index == '0 && !m_data.winner_was_incumbent)
        else $error("result without winner carries index or incumbent flag");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    a_ready_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_valid && !m_valid |=> s_ready || $past(s_valid))
        else $error("input stalled with nothing pending");

endmodule

bind bgp_best_path_select bgpbps_checker u_checker (.*);

`default_nettype wire

>>> test/bgp_best_path_select_check.sv
`default_nettype none

module bgp_best_path_select_check #(
    parameter int MAX_CANDIDATES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire bgpbps_pkg::cand_t   s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire bgpbps_pkg::result_t m_data,
    output int                       fail_count,
    output int                       pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import bgpbps_pkg::*;

    logic             have_best;
    logic             run_locked;
    int unsigned      run_position;
    logic [IDX_W-1:0] best_index;
    cand_t            held_best;
    result_t          expected_winners[$];

    function automatic logic route_beats_held(input cand_t c);
        if (c.local_preference != held_best.local_preference)
            return c.local_preference > held_best.local_preference;
        if (c.as_path_length != held_best.as_path_length)
            return c.as_path_length < held_best.as_path_length;
        if (c.origin_code != held_best.origin_code)
            return c.origin_code < held_best.origin_code;
        if (c.neighbour_as == held_best.neighbour_as &&
            c.multi_exit_disc != held_best.multi_exit_disc)
            return c.multi_exit_disc < held_best.multi_exit_disc;
        if (c.from_internal_peer != held_best.from_internal_peer)
            return !c.from_internal_peer;
        if (c.igp_metric != held_best.igp_metric)
            return c.igp_metric < held_best.igp_metric;
        if (c.peer_router_id != held_best.peer_router_id)
            return c.peer_router_id < held_best.peer_router_id;
        if (c.peer_address != held_best.peer_address)
            return c.peer_address < held_best.peer_address;
        return 1'b0;
    endfunction

    function automatic void clear_run();
        have_best    = 1'b0;
        run_locked   = 1'b0;
        run_position = 0;
        best_index   = '0;
        held_best    = '0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic select_candidate(input cand_t c);
        result_t r;
        if (run_position < MAX_CANDIDATES) begin
            if (!run_locked) begin
                if (c.candidate_status == STAT_WINNER) begin
                    held_best  = c;
                    best_index = run_position[IDX_W-1:0];
                    have_best  = 1'b1;
                    run_locked = 1'b1;
                end else if (c.candidate_status == STAT_RESOLVABLE &&
                             (!have_best || route_beats_held(c))) begin
                    held_best  = c;
                    best_index = run_position[IDX_W-1:0];
                    have_best  = 1'b1;
                end
            end
            run_position++;
        end
        if (c.last_candidate) begin
            r.winner_found         = have_best;
            r.winner_index         = have_best ? best_index : '0;
            r.winner_was_incumbent = have_best && run_locked;
            expected_winners.push_back(r);
            clear_run();
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            clear_run();
            expected_winners.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_winners.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: found %0b index %0d",
                                              m_data.winner_found, m_data.winner_index));
                end else begin
                    want = expected_winners.pop_front();
                    if (m_data.winner_found !== want.winner_found)
                        report_mismatch($sformatf("winner_found %0b, expected %0b",
                                                  m_data.winner_found, want.winner_found));
                    if (m_data.winner_index !== want.winner_index)
                        report_mismatch($sformatf("winner_index %0d, expected %0d",
                                                  m_data.winner_index, want.winner_index));
                    if (m_data.winner_was_incumbent !== want.winner_was_incumbent)
                        report_mismatch($sformatf("winner_was_incumbent %0b, expected %0b",
                                                  m_data.winner_was_incumbent,
                                                  want.winner_was_incumbent));
                end
            end
            if (s_valid && s_ready)
                select_candidate(s_data);
        end
        pending_results = expected_winners.size();
    end

endmodule

`default_nettype wire

>>> test/bgp_best_path_select_test.sv
`default_nettype none

module bgp_best_path_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bgpbps_pkg::*;

    localparam int MAX_CANDIDATES = 16;
    localparam int TOTAL_ITEMS    = 1850;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 600;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    cand_t   s_data;
    logic    m_valid;
    logic    m_ready;
    result_t m_data;

    int fail_count;
    int pending_results;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    bit sender_gaps = 1'b1;
    bit hold_done   = 1'b0;

    bgp_best_path_select #(
        .MAX_CANDIDATES(MAX_CANDIDATES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bgp_best_path_select_check #(
        .MAX_CANDIDATES(MAX_CANDIDATES)
    ) route_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_word(input logic [31:0] common);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return common + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic cand_t random_candidate(input logic last);
        cand_t c;
        case ($urandom_range(0, 19))
            0, 1, 2: c.candidate_status = STAT_SKIP;
            3, 4, 5: c.candidate_status = STAT_UNRESOLVABLE;
            6:       c.candidate_status = STAT_WINNER;
            default: c.candidate_status = STAT_RESOLVABLE;
        endcase
        c.local_preference = pick_word(32'd100);
        case ($urandom_range(0, 3))
            0:       c.as_path_length = 8'(pick_word(32'd0));
            1:       c.as_path_length = 8'($urandom);
            default: c.as_path_length = 8'($urandom_range(1, 4));
        endcase
        c.origin_code        = 2'($urandom_range(0, 3));
        c.multi_exit_disc    = pick_word(32'd50);
        c.neighbour_as       = pick_word(32'd65000);
        c.from_internal_peer = 1'($urandom_range(0, 1));
        c.igp_metric         = pick_word(32'd20);
        c.peer_router_id     = pick_word(32'h0a00_0001);
        c.peer_address       = pick_word(32'h0a00_0001);
        c.last_candidate     = last;
        return c;
    endfunction

    function automatic cand_t worst_route();
        cand_t c;
        c.candidate_status   = STAT_RESOLVABLE;
        c.local_preference   = '0;
        c.as_path_length     = '1;
        c.origin_code        = 2'd3;
        c.multi_exit_disc    = '1;
        c.neighbour_as       = 32'd64512;
        c.from_internal_peer = 1'b1;
        c.igp_metric         = '1;
        c.peer_router_id     = '1;
        c.peer_address       = '1;
        c.last_candidate     = 1'b0;
        return c;
    endfunction

    task automatic offer_candidate(input cand_t c);
        if (sender_gaps && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    initial begin : result_sink
        int mode = 0;
        int span = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= (span % 4 != 0);
            endcase
        end
    end

    initial begin : candidate_source
        cand_t a;
        cand_t b;
        int    run_len;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        a = worst_route();
        a.candidate_status = STAT_SKIP;
        a.last_candidate   = 1'b1;
        offer_candidate(a);

        for (int k = 0; k < 10; k++) begin
            a = worst_route();
            b = a;
            b.last_candidate = 1'b1;
            case (k)
                0: b.local_preference = '1;
                1: b.as_path_length = '0;
                2: b.origin_code = 2'd0;
                3: b.multi_exit_disc = '0;
                4: begin
                    b.multi_exit_disc = '0;
                    b.neighbour_as    = 32'd65001;
                end
                5: b.from_internal_peer = 1'b0;
                6: b.igp_metric = '0;
                7: b.peer_router_id = '0;
                8: b.peer_address = '0;
                default: ;
            endcase
            offer_candidate(a);
            offer_candidate(b);
        end

        a = worst_route();
        a.candidate_status = STAT_UNRESOLVABLE;
        a.local_preference = '1;
        offer_candidate(a);
        offer_candidate(worst_route());
        a = worst_route();
        a.candidate_status = STAT_WINNER;
        offer_candidate(a);
        a.candidate_status = STAT_RESOLVABLE;
        a.local_preference = '1;
        offer_candidate(a);
        a.candidate_status = STAT_WINNER;
        a.last_candidate   = 1'b1;
        offer_candidate(a);

        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       run_len = $urandom_range(17, 20);
                1, 2:    run_len = $urandom_range(9, 16);
                default: run_len = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < run_len; i++) begin
                sender_gaps = !(items_sent >= 1200 && items_sent < 1400);
                offer_candidate(random_candidate(i == run_len - 1));
            end
        end
        s_valid <= 1'b0;

        wait (pending_results == 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/bgpbps_pkg.sv
hw/rtl/bgpbps_front.sv
hw/rtl/bgpbps_queue.sv
hw/rtl/bgpbps_back.sv
hw/rtl/bgp_best_path_select.sv
hw/rtl/bgpbps_checker.sv
test/bgp_best_path_select_check.sv
test/bgp_best_path_select_test.sv
